// ===== src/dpa_pkg.sv =====
// Shared widths, codes and control structures of the descriptor pool allocator.
`timescale 1ns / 1ps

package dpa_pkg;

    localparam int DESCRIPTORS = 8;
    localparam int TAKE_COUNT  = 3;

    localparam int IDX_W    = 8;
    localparam int SLOT_W   = $clog2(DESCRIPTORS);
    localparam int STEP_W   = $clog2(DESCRIPTORS);
    localparam int PICK_W   = $clog2(TAKE_COUNT);
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LINK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic load;
        logic pick;
        logic link;
        logic walk;
        logic emit;
    } dpa_ctl_t;

    typedef struct packed {
        logic pick_none;
        logic pick_last;
        logic walk_done;
        logic out_free;
    } dpa_stat_t;

endpackage

// ===== src/descriptor_pool_allocator_unit.sv =====
// Top level of the descriptor pool allocator: stream ports, controller and datapath.
//
// Channel  Direction  tdata (lowest bit up)                          tuser
// s_*      in         entry_index, link_target, has_link, zero pad   command
// m_*      out        first_index, second_index, third_index         status
//
// An input transaction is taken when the block is idle.
// Allocate then takes up to three free entries in the picker, set-link writes one entry's link,
// and free releases each chain entry walked, at most DESCRIPTORS.
// The result register is then loaded once the output register has room.
// Reset leaves every entry free with its link cleared; no clearing pass is needed.
// A result held by a stalled output lets the next transaction in, but not out.
`timescale 1ns / 1ps

module descriptor_pool_allocator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dpa_pkg::S_DATA_W-1:0]  s_tdata,  // entry_index, link_target, has_link
    input  logic [dpa_pkg::CMD_W-1:0]     s_tuser,  // command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dpa_pkg::M_DATA_W-1:0]  m_tdata,  // first_index, second_index, third_index
    output logic [dpa_pkg::STATUS_W-1:0]  m_tuser   // status
);
    import dpa_pkg::*;

    dpa_ctl_t         ctl;
    dpa_stat_t        stat;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] second_index;
    logic [IDX_W-1:0] third_index;

    dpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .command  (s_tuser),
        .stat     (stat),
        .ctl      (ctl)
    );

    dpa_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .entry_index (s_tdata[7:0]),
        .link_target (s_tdata[15:8]),
        .has_link    (s_tdata[16]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_status    (m_tuser),
        .m_first     (first_index),
        .m_second    (second_index),
        .m_third     (third_index)
    );

    assign m_tdata = {third_index, second_index, first_index};

endmodule

// ===== src/dpa_ctrl.sv =====
// Controller state machine that sequences each command of the allocator.
`timescale 1ns / 1ps

module dpa_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [dpa_pkg::CMD_W-1:0] command,
    input  dpa_pkg::dpa_stat_t       stat,
    output dpa_pkg::dpa_ctl_t        ctl
);
    import dpa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_LINK,
        S_WALK,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctl.load = 1'b1;
                    case (command)
                        CMD_ALLOC: state_next = S_ALLOC;
                        CMD_LINK:  state_next = S_LINK;
                        CMD_FREE:  state_next = S_WALK;
                        default:   state_next = S_EMIT;
                    endcase
                end
            end
            S_ALLOC:
            begin
                ctl.pick = 1'b1;
                if (stat.pick_none || stat.pick_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_LINK:
            begin
                ctl.link   = 1'b1;
                state_next = S_EMIT;
            end
            S_WALK:
            begin
                ctl.walk = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("A new transaction was accepted while a command was in progress.");

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> stat.out_free)
        else $error("A result was loaded while the output register was still full.");

    a_single_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.load, ctl.pick, ctl.link, ctl.walk, ctl.emit}))
        else $error("More than one datapath command was issued in one cycle.");

endmodule

// ===== src/dpa_datapath.sv =====
// Datapath with the descriptor pool state, the allocation picker and the chain walker.
`timescale 1ns / 1ps

module dpa_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dpa_pkg::dpa_ctl_t           ctl,
    output dpa_pkg::dpa_stat_t          stat,
    input  logic [dpa_pkg::IDX_W-1:0]   entry_index,
    input  logic [dpa_pkg::IDX_W-1:0]   link_target,
    input  logic                        has_link,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [dpa_pkg::STATUS_W-1:0] m_status,
    output logic [dpa_pkg::IDX_W-1:0]   m_first,
    output logic [dpa_pkg::IDX_W-1:0]   m_second,
    output logic [dpa_pkg::IDX_W-1:0]   m_third
);
    import dpa_pkg::*;

    logic [DESCRIPTORS-1:0] free_map_reg;
    logic [IDX_W-1:0]       next_link_reg [DESCRIPTORS];
    logic [DESCRIPTORS-1:0] chain_flag_reg;

    logic [IDX_W-1:0]       cursor_reg;
    logic [IDX_W-1:0]       target_reg;
    logic                   link_flag_reg;
    logic [DESCRIPTORS-1:0] scratch_reg;
    logic [PICK_W-1:0]      pick_cnt_reg;
    logic [IDX_W-1:0]       picks_reg [TAKE_COUNT];
    logic [STEP_W-1:0]      step_reg;
    logic [STATUS_W-1:0]    status_reg;

    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [IDX_W-1:0]       out_first_reg;
    logic [IDX_W-1:0]       out_second_reg;
    logic [IDX_W-1:0]       out_third_reg;

    logic [IDX_W-1:0]       low_index;
    logic [DESCRIPTORS-1:0] low_onehot;
    logic                   pick_none;
    logic                   pick_last;
    logic                   cur_in_range;
    logic [SLOT_W-1:0]      cur_slot;
    logic                   cur_flag;
    logic [SLOT_W-1:0]      entry_slot;
    logic                   entry_in_range;

    always_comb
    begin
        low_index  = '0;
        low_onehot = '0;
        for (int i = DESCRIPTORS - 1; i >= 0; i--)
        begin
            if (scratch_reg[i])
            begin
                low_index  = IDX_W'(i);
                low_onehot = DESCRIPTORS'(1) << i;
            end
        end
    end

    assign pick_none      = (scratch_reg == '0);
    assign pick_last      = (pick_cnt_reg == PICK_W'(TAKE_COUNT - 1));
    assign cur_in_range   = ({1'b0, cursor_reg} < (IDX_W + 1)'(DESCRIPTORS));
    assign cur_slot       = cursor_reg[SLOT_W-1:0];
    assign cur_flag       = cur_in_range ? chain_flag_reg[cur_slot] : 1'b0;
    assign entry_in_range = ({1'b0, cursor_reg} < (IDX_W + 1)'(DESCRIPTORS));
    assign entry_slot     = cursor_reg[SLOT_W-1:0];

    assign stat.pick_none = pick_none;
    assign stat.pick_last = pick_last;
    assign stat.walk_done = !cur_in_range || !cur_flag
                            || (step_reg == STEP_W'(DESCRIPTORS - 1));
    assign stat.out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_map_reg   <= '1;
            chain_flag_reg <= '0;
            for (int i = 0; i < DESCRIPTORS; i++)
            begin
                next_link_reg[i] <= '0;
            end
        end
        else
        begin
            if (ctl.pick && !pick_none && pick_last)
            begin
                free_map_reg <= scratch_reg & ~low_onehot;
            end
            if (ctl.link && entry_in_range)
            begin
                next_link_reg[entry_slot]  <= target_reg;
                chain_flag_reg[entry_slot] <= link_flag_reg;
            end
            if (ctl.walk && cur_in_range)
            begin
                next_link_reg[cur_slot]  <= '0;
                chain_flag_reg[cur_slot] <= 1'b0;
                free_map_reg[cur_slot]   <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cursor_reg    <= entry_index;
            target_reg    <= link_target;
            link_flag_reg <= has_link;
            scratch_reg   <= free_map_reg;
            pick_cnt_reg  <= '0;
            step_reg      <= '0;
            status_reg    <= ST_OK;
            for (int i = 0; i < TAKE_COUNT; i++)
            begin
                picks_reg[i] <= '0;
            end
        end
        if (ctl.pick)
        begin
            if (pick_none)
            begin
                status_reg <= ST_SHORT;
                for (int i = 0; i < TAKE_COUNT; i++)
                begin
                    picks_reg[i] <= '0;
                end
            end
            else
            begin
                picks_reg[pick_cnt_reg] <= low_index;
                scratch_reg             <= scratch_reg & ~low_onehot;
                pick_cnt_reg            <= pick_cnt_reg + PICK_W'(1);
            end
        end
        if (ctl.link && !entry_in_range)
        begin
            status_reg <= ST_RANGE;
        end
        if (ctl.walk)
        begin
            if (cur_in_range)
            begin
                cursor_reg <= next_link_reg[cur_slot];
                step_reg   <= step_reg + STEP_W'(1);
            end
            else
            begin
                status_reg <= ST_RANGE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_status_reg <= status_reg;
            out_first_reg  <= picks_reg[0];
            out_second_reg <= picks_reg[1];
            out_third_reg  <= picks_reg[2];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_status = out_status_reg;
    assign m_first  = out_first_reg;
    assign m_second = out_second_reg;
    assign m_third  = out_third_reg;

    a_error_has_no_indexes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK)
        |-> (out_first_reg == '0 && out_second_reg == '0 && out_third_reg == '0))
        else $error("A failed command returned non-zero entry indexes.");

    a_short_pool_status: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.pick && pick_none) |=> (status_reg == ST_SHORT))
        else $error("An exhausted pool did not give the short status.");

    a_walk_releases_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.walk && cur_in_range)
        |=> (free_map_reg[$past(cur_slot)] && !chain_flag_reg[$past(cur_slot)]))
        else $error("A walked entry was not released.");

endmodule
